>>> rtl/clcd_pkg.sv
// ----------------------------------------------------------------------------
// clcd_pkg
// shared types, command bytes and lookup functions for the lcd sequencer
// ----------------------------------------------------------------------------
package clcd_pkg;

    // field widths
    localparam int ACTION_W   = 3;
    localparam int MODE_W     = 2;
    localparam int COLUMN_W   = 6;
    localparam int ROW_W      = 3;
    localparam int CHAR_W     = 8;
    localparam int CPL_W      = 6;
    localparam int LINES_W    = 3;
    localparam int SETTLE_W   = 12;
    localparam int STEP_W     = 6;
    localparam int VCOL_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 24;

    // job queue between front and back
    localparam int JOBQ_DEPTH = 2;
    localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);
    localparam int JOBQ_CW    = $clog2(JOBQ_DEPTH + 1);

    // register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_PER_LINE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT     = 1'd1;
    localparam logic [CPL_W-1:0]     CPL_RESET          = 6'd16;
    localparam logic [LINES_W-1:0]   LINES_RESET        = 3'd2;

    // panel command bytes
    localparam logic [7:0] CMD_INIT_NIBBLE  = 8'h02;
    localparam logic [7:0] CMD_FUNC_SET     = 8'h28;
    localparam logic [7:0] CMD_CLEAR        = 8'h01;
    localparam logic [7:0] CMD_HOME         = 8'h02;
    localparam logic [7:0] CMD_LINE0        = 8'h80;
    localparam logic [7:0] CMD_LINE1        = 8'hC0;
    localparam logic [7:0] CMD_DISP_OFF     = 8'h08;
    localparam logic [7:0] CMD_DISP_ON      = 8'h0C;
    localparam logic [7:0] CMD_DISP_CURSOR  = 8'h0E;
    localparam logic [7:0] CMD_DISP_BLINK   = 8'h0F;
    localparam logic [7:0] CMD_SHIFT_RIGHT  = 8'h14;

    localparam logic [SETTLE_W-1:0] SETTLE_US      = 12'd1024;
    localparam logic [SETTLE_W-1:0] SETTLE_INIT_US = 12'd2048;
    localparam logic [VCOL_W-1:0]   MAX_VIRT_COL   = 8'd39;
    localparam logic [STEP_W-1:0]   INIT_LAST_STEP = 6'd4;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INIT   = 3'd0,
        ACT_CLEAR  = 3'd1,
        ACT_HOME   = 3'd2,
        ACT_MODE   = 3'd3,
        ACT_CURSOR = 3'd4,
        ACT_PRINT  = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        JOB_REJECT = 2'd0,
        JOB_INIT   = 2'd1,
        JOB_SINGLE = 2'd2,
        JOB_CURSOR = 2'd3
    } job_kind_t;

    typedef struct packed {
        job_kind_t         kind;
        logic              rs;
        logic [7:0]        value;
        logic [STEP_W-1:0] last_step;
    } job_t;

    // queue status seen by the top level and the back
    typedef struct packed {
        logic full;
        logic empty;
    } jobq_status_t;

    typedef enum logic {
        BACK_IDLE = 1'b0,
        BACK_RUN  = 1'b1
    } back_state_t;

    function automatic logic [7:0] mode_cmd(input logic [MODE_W-1:0] mode);
        logic [7:0] cmd;
        case (mode)
            2'd0:    cmd = CMD_DISP_OFF;
            2'd1:    cmd = CMD_DISP_ON;
            2'd2:    cmd = CMD_DISP_CURSOR;
            default: cmd = CMD_DISP_BLINK;
        endcase
        return cmd;
    endfunction

    function automatic logic [7:0] init_byte(input logic [2:0] step);
        logic [7:0] b;
        case (step)
            3'd0:    b = CMD_INIT_NIBBLE;
            3'd1:    b = CMD_FUNC_SET;
            3'd2:    b = CMD_CLEAR;
            3'd3:    b = CMD_LINE0;
            default: b = CMD_DISP_ON;
        endcase
        return b;
    endfunction

endpackage

>>> rtl/clcd_front.sv
// ----------------------------------------------------------------------------
// clcd_front
// request classification, config registers and initialized flag
// ----------------------------------------------------------------------------
module clcd_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [clcd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [clcd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              push,
    input  logic [clcd_pkg::ACTION_W-1:0]     action,
    input  logic [clcd_pkg::MODE_W-1:0]       disp_sel,
    input  logic [clcd_pkg::COLUMN_W-1:0]     column,
    input  logic [clcd_pkg::ROW_W-1:0]        row,
    input  logic [clcd_pkg::CHAR_W-1:0]       char_code,
    output clcd_pkg::job_t                    job
);
    import clcd_pkg::*;

    logic [CPL_W-1:0]   chars_per_line_reg;
    logic [LINES_W-1:0] line_count_reg;
    logic               initialized_reg;
    logic               initialized_next;

    logic [VCOL_W-1:0]  row_offset;
    logic [VCOL_W-1:0]  vcol;
    logic               cfg_bad;
    logic               cursor_bad;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            chars_per_line_reg <= CPL_RESET;
            line_count_reg     <= LINES_RESET;
        end
        else if (cfg_we) begin
            if (cfg_index == REG_CHARS_PER_LINE)
                chars_per_line_reg <= cfg_data[CPL_W-1:0];
            if (cfg_index == REG_LINE_COUNT)
                line_count_reg <= cfg_data[LINES_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            initialized_reg <= 1'b0;
        else if (push)
            initialized_reg <= initialized_next;
    end

    // rows past the first pair continue the two hardware lines
    assign row_offset = VCOL_W'(row[ROW_W-1:1]) * VCOL_W'(chars_per_line_reg);
    assign vcol       = VCOL_W'(column) + row_offset;
    assign cfg_bad    = (chars_per_line_reg == '0) || (line_count_reg == '0);
    assign cursor_bad = (column >= COLUMN_W'(chars_per_line_reg))
                     || (row >= line_count_reg)
                     || (vcol > MAX_VIRT_COL);

    always_comb begin
        job.kind         = JOB_REJECT;
        job.rs           = 1'b0;
        job.value        = '0;
        job.last_step    = '0;
        initialized_next = initialized_reg;
        unique case (action)
            ACT_INIT: begin
                if (cfg_bad) begin
                    initialized_next = 1'b0;
                end
                else begin
                    job.kind         = JOB_INIT;
                    job.last_step    = INIT_LAST_STEP;
                    initialized_next = 1'b1;
                end
            end
            ACT_CLEAR: begin
                if (initialized_reg) begin
                    job.kind  = JOB_SINGLE;
                    job.value = CMD_CLEAR;
                end
            end
            ACT_HOME: begin
                if (initialized_reg) begin
                    job.kind  = JOB_SINGLE;
                    job.value = CMD_HOME;
                end
            end
            ACT_MODE: begin
                if (initialized_reg) begin
                    job.kind  = JOB_SINGLE;
                    job.value = mode_cmd(disp_sel);
                end
            end
            ACT_CURSOR: begin
                if (initialized_reg && !cursor_bad) begin
                    job.kind      = JOB_CURSOR;
                    job.value     = row[0] ? CMD_LINE1 : CMD_LINE0;
                    job.last_step = vcol[STEP_W-1:0];
                end
            end
            ACT_PRINT: begin
                if (initialized_reg) begin
                    job.kind  = JOB_SINGLE;
                    job.rs    = 1'b1;
                    job.value = char_code;
                end
            end
            default: ;
        endcase
    end

endmodule

>>> rtl/clcd_jobq.sv
// ----------------------------------------------------------------------------
// clcd_jobq
// short job queue between the front and the back
// ----------------------------------------------------------------------------
module clcd_jobq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  clcd_pkg::job_t         push_job,
    input  logic                   pop,
    output clcd_pkg::job_t         head,
    output clcd_pkg::jobq_status_t status
);
    import clcd_pkg::*;

    job_t               mem_reg [JOBQ_DEPTH];
    logic [JOBQ_AW-1:0] wr_ptr_reg;
    logic [JOBQ_AW-1:0] rd_ptr_reg;
    logic [JOBQ_CW-1:0] count_reg;

    function automatic logic [JOBQ_AW-1:0] ptr_inc(input logic [JOBQ_AW-1:0] p);
        return (p == JOBQ_AW'(JOBQ_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk) begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == JOBQ_CW'(JOBQ_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

>>> rtl/clcd_back.sv
// ----------------------------------------------------------------------------
// clcd_back
// expands one job into its run of panel transfers, or one rejection, through an output register
// ----------------------------------------------------------------------------
module clcd_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  clcd_pkg::job_t                    head,
    input  clcd_pkg::jobq_status_t            status,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [clcd_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast
);
    import clcd_pkg::*;

    back_state_t          state_reg, state_next;
    job_t                 job_reg, job_next;
    logic [STEP_W-1:0]    step_reg, step_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                 m_tuser_reg, m_tuser_next;
    logic                 m_tlast_reg, m_tlast_next;

    logic                 out_free;
    logic                 is_last;
    logic                 r_transfer;
    logic                 r_rs;
    logic [7:0]           r_value;
    logic                 r_single;
    logic [SETTLE_W-1:0]  r_settle;

    assign out_free = !m_tvalid_reg || m_tready;
    assign is_last  = (step_reg == job_reg.last_step);

    // result of the current step
    always_comb begin
        r_transfer = 1'b1;
        r_rs       = 1'b0;
        r_value    = job_reg.value;
        r_single   = 1'b0;
        r_settle   = SETTLE_US;
        unique case (job_reg.kind)
            JOB_REJECT: begin
                r_transfer = 1'b0;
                r_value    = '0;
                r_settle   = '0;
            end
            JOB_INIT: begin
                r_value  = init_byte(step_reg[2:0]);
                r_single = (step_reg == '0);
                r_settle = (step_reg == '0) ? SETTLE_INIT_US : SETTLE_US;
            end
            JOB_SINGLE: begin
                r_rs = job_reg.rs;
            end
            JOB_CURSOR: begin
                r_value = (step_reg == '0) ? job_reg.value : CMD_SHIFT_RIGHT;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg    <= BACK_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk) begin
        job_reg     <= job_next;
        step_reg    <= step_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    always_comb begin
        state_next    = state_reg;
        job_next      = job_reg;
        step_next     = step_reg;
        pop           = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        unique case (state_reg)
            BACK_IDLE: begin
                if (!status.empty) begin
                    pop        = 1'b1;
                    job_next   = head;
                    step_next  = '0;
                    state_next = BACK_RUN;
                end
            end
            BACK_RUN: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, r_transfer, r_settle, r_single,
                                     r_value, r_transfer};
                    m_tuser_next  = r_rs;
                    m_tlast_next  = is_last;
                    if (is_last)
                        state_next = BACK_IDLE;
                    else
                        step_next = step_reg + 1'b1;
                end
            end
            default: state_next = BACK_IDLE;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

>>> rtl/char_lcd_4bit_command_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_4bit_command_sequencer
// turns lcd requests into runs of 4-bit-mode panel transfers
// ----------------------------------------------------------------------------
//
// channel   direction  handshake            payload
// -------   ---------  ---------            -------
// s_*       in         s_tvalid / s_tready  one request (action in s_tuser)
// m_*       out        m_tvalid / m_tready  one transfer or rejection, tlast ends it
// cfg_*     in         cfg_we               chars_per_line, line_count
//
// the front classifies a request in the cycle it is accepted and pushes one job
// into a two-entry queue; s_tready is low only while that queue is full.
// the back loads a job from the queue while idle, then emits one result per cycle while
// m_tready is high, up to the job's last step; a rejection job gives a single result.
// a stalled m_tready holds the output register and the back; the front keeps accepting
// until the queue fills. reset clears queue, flag and output valid, config to 16 x 2.
//
module char_lcd_4bit_command_sequencer (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration writes
    input  logic                              cfg_we,
    input  logic [clcd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [clcd_pkg::CFG_DATA_W-1:0]   cfg_data,
    // request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // disp_sel[1:0], column[7:2], row[10:8], char_code[18:11], zero pad
    input  logic [clcd_pkg::S_TDATA_W-1:0]    s_tdata,
    // action[2:0]
    input  logic [clcd_pkg::ACTION_W-1:0]     s_tuser,
    // transfer stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // transfer[0], value[8:1], single_nibble[9], settle_us[21:10], ok[22], pad
    output logic [clcd_pkg::M_TDATA_W-1:0]    m_tdata,
    // register_select
    output logic                              m_tuser,
    output logic                              m_tlast
);
    import clcd_pkg::*;

    logic         push;
    logic         pop;
    job_t         new_job;
    job_t         head_job;
    jobq_status_t q_status;

    // a request transfer happens whenever s_tvalid is high and the queue has room
    assign s_tready = !q_status.full;
    assign push     = s_tvalid && s_tready;

    // front: classify the request and track the initialized flag
    clcd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .action       (s_tuser),
        .disp_sel     (s_tdata[1:0]),
        .column       (s_tdata[7:2]),
        .row          (s_tdata[10:8]),
        .char_code    (s_tdata[18:11]),
        .job          (new_job)
    );

    // queue decouples request acceptance from transfer output
    clcd_jobq u_jobq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (new_job),
        .pop      (pop),
        .head     (head_job),
        .status   (q_status)
    );

    // back: walk the job one transfer per cycle while the output register is free
    clcd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head_job),
        .status   (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    // a rejection is always a single, final result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[22] |-> m_tlast && !m_tdata[0])
    else $error("rejection result not final or carries a transfer");

    // the init nibble is never the end of a run and always gets the long settle
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[9] |-> !m_tlast && m_tdata[21:10] == SETTLE_INIT_US)
    else $error("init nibble result malformed");

    // the back never pops an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
    else $error("job queue underflow");

    // a full queue and a pop leave room on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full && pop |=> s_tready)
    else $error("queue slot not freed after pop");
`endif

endmodule
